[src/frs_pkg.sv]
// ----------------------------------------------------------------------------
// frs_pkg
// Shared constants and types for the distinct recent-id set.
// ----------------------------------------------------------------------------
package frs_pkg;

    localparam int DEPTH = 16;
    localparam int ID_W  = 32;
    localparam int CNT_W = 5;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    localparam logic REQ_OFFER = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam logic KIND_OFFER = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    // Control for the row: shift, clear and cap reach every cell; rd_idx selects the readout slot.
    typedef struct packed {
        logic             shift;
        logic             clear;
        logic [CNT_W-1:0] cap;
        logic [IDX_W-1:0] rd_idx;
    } frs_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } frs_state_t;

endpackage

[src/frs_cell.sv]
// ----------------------------------------------------------------------------
// frs_cell
// One slot of the set: holds an id and its valid bit, compares against the
// offered id and takes its neighbor's contents on an insert.
// ----------------------------------------------------------------------------
module frs_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     shift,
    input  logic                     clear,
    input  logic                     allow,
    input  logic [frs_pkg::ID_W-1:0] prev_id,
    input  logic                     prev_valid,
    input  logic [frs_pkg::ID_W-1:0] cmp_id,
    output logic [frs_pkg::ID_W-1:0] id,
    output logic                     valid,
    output logic                     match
);
    import frs_pkg::*;

    logic [ID_W-1:0] id_reg;
    logic            valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            // a slot beyond capacity drops what would move into it
            valid_reg <= prev_valid & allow;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            id_reg <= prev_id;
        end
    end

    assign id    = id_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (id_reg == cmp_id);

endmodule

[src/frs_chain.sv]
// ----------------------------------------------------------------------------
// frs_chain
// Row of cells, newest at slot 0. Gathers the hit flag and selects one
// slot for readout or eviction.
// ----------------------------------------------------------------------------
module frs_chain (
    input  logic                     clk,
    input  logic                     rst_n,
    input  frs_pkg::frs_ctrl_t       ctrl,
    input  logic [frs_pkg::ID_W-1:0] cmp_id,
    output logic                     hit,
    output logic [frs_pkg::ID_W-1:0] rd_id
);
    import frs_pkg::*;

    logic [ID_W-1:0] ids   [DEPTH];
    logic [DEPTH-1:0] valids;
    logic [DEPTH-1:0] hit_vec;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ID_W-1:0] prev_id;
        logic            prev_valid;
        logic            allow;

        if (i == 0)
        begin : g_head
            assign prev_id    = cmp_id;
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_id    = ids[i-1];
            assign prev_valid = valids[i-1];
        end

        assign allow = (CNT_W'(i) < ctrl.cap);

        frs_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (ctrl.shift),
            .clear      (ctrl.clear),
            .allow      (allow),
            .prev_id    (prev_id),
            .prev_valid (prev_valid),
            .cmp_id     (cmp_id),
            .id         (ids[i]),
            .valid      (valids[i]),
            .match      (hit_vec[i])
        );
    end

    assign hit   = |hit_vec;
    assign rd_id = ids[ctrl.rd_idx];

endmodule

[src/fifo_distinct_recent_set.sv]
// ----------------------------------------------------------------------------
// fifo_distinct_recent_set
// FIFO set of up to DEPTH distinct ids, newest first, with dedup on offer,
// eviction of the oldest when full, and a newest-first readout.
// ----------------------------------------------------------------------------
// Offer: result registered at accept; one offer per cycle while idle and the
//   result register drains (cell row compares and shifts at the accept edge).
// Readout: n results for n held ids (one if empty), one per cycle when
//   not stalled; the next item is taken once the last entry is registered.
// Reset: set empty, capacity 16, result register empty.
module fifo_distinct_recent_set (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [frs_pkg::CNT_W-1:0] cfg_wr_data,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic                      req_type,
    input  logic [frs_pkg::ID_W-1:0]  new_id,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output logic                      kind,
    output logic                      inserted,
    output logic                      evicted,
    output logic [frs_pkg::ID_W-1:0]  evicted_id,
    output logic [frs_pkg::ID_W-1:0]  entry_value,
    output logic                      entry_valid,
    output logic [frs_pkg::CNT_W-1:0] count,
    output logic                      last
);
    import frs_pkg::*;

    frs_state_t       state_reg, state_next;
    logic [CNT_W-1:0] capacity_reg;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cap_eff;

    logic             out_valid_reg, out_valid_next;
    logic             kind_reg, kind_next;
    logic             ins_reg, ins_next;
    logic             ev_reg, ev_next;
    logic [ID_W-1:0]  ev_id_reg, ev_id_next;
    logic [ID_W-1:0]  val_reg, val_next;
    logic             vld_reg, vld_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_reg, last_next;

    frs_ctrl_t        ctrl;
    logic             hit;
    logic [ID_W-1:0]  rd_id;
    logic             slot_free;
    logic             accept;
    logic             full;
    logic             read_last;

    always_comb
    begin
        if (capacity_reg == '0)
            cap_eff = CNT_W'(1);
        else if (capacity_reg > CNT_W'(DEPTH))
            cap_eff = CNT_W'(DEPTH);
        else
            cap_eff = capacity_reg;
    end

    assign slot_free = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && slot_free;
    assign accept    = req_valid && req_ready;
    assign full      = (held_reg >= cap_eff);
    assign read_last = ({1'b0, idx_reg} == held_reg - CNT_W'(1));

    always_comb
    begin
        ctrl.cap    = cap_eff;
        ctrl.clear  = cfg_wr_en;
        ctrl.shift  = accept && (req_type == REQ_OFFER) && !hit;
        // idle: point at the oldest slot for a possible eviction
        ctrl.rd_idx = (state_reg == ST_READ) ? idx_reg : IDX_W'(cap_eff - CNT_W'(1));
    end

    frs_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .cmp_id (new_id),
        .hit    (hit),
        .rd_id  (rd_id)
    );

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        kind_next      = kind_reg;
        ins_next       = ins_reg;
        ev_next        = ev_reg;
        ev_id_next     = ev_id_reg;
        val_next       = val_reg;
        vld_next       = vld_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    ins_next       = 1'b0;
                    ev_next        = 1'b0;
                    ev_id_next     = '0;
                    val_next       = '0;
                    vld_next       = 1'b0;
                    last_next      = 1'b1;
                    if (req_type == REQ_OFFER)
                    begin
                        kind_next = KIND_OFFER;
                        if (!hit)
                        begin
                            ins_next = 1'b1;
                            if (full)
                            begin
                                ev_next    = 1'b1;
                                ev_id_next = rd_id;
                            end
                            else
                            begin
                                held_next = held_reg + CNT_W'(1);
                            end
                        end
                        cnt_next = hit ? held_reg : (full ? held_reg : held_reg + CNT_W'(1));
                    end
                    else
                    begin
                        kind_next = KIND_ENTRY;
                        cnt_next  = held_reg;
                        if (held_reg != '0)
                        begin
                            // entries come out of the read state instead
                            out_valid_next = out_valid_reg && !rsp_ready;
                            idx_next       = '0;
                            state_next     = ST_READ;
                        end
                    end
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ENTRY;
                    ins_next       = 1'b0;
                    ev_next        = 1'b0;
                    ev_id_next     = '0;
                    val_next       = rd_id;
                    vld_next       = 1'b1;
                    cnt_next       = held_reg;
                    last_next      = read_last;
                    if (read_last)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en)
            held_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAP_RESET;
            held_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                capacity_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        ins_reg   <= ins_next;
        ev_reg    <= ev_next;
        ev_id_reg <= ev_id_next;
        val_reg   <= val_next;
        vld_reg   <= vld_next;
        cnt_reg   <= cnt_next;
        last_reg  <= last_next;
    end

    assign rsp_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign inserted    = ins_reg;
    assign evicted     = ev_reg;
    assign evicted_id  = ev_id_reg;
    assign entry_value = val_reg;
    assign entry_valid = vld_reg;
    assign count       = cnt_reg;
    assign last        = last_reg;

endmodule

[test/fifo_distinct_recent_set_tb.sv]
// ----------------------------------------------------------------------------
// fifo_distinct_recent_set_tb
// Self-checking bench for the distinct recent-id set. A directed table
// covers the empty readout, hits, the id extremes, eviction and capacity
// clamping. Random phases then run at several capacity settings with bursty
// offers and readouts against a behavioral copy of the set, while the
// response side stalls on its own pattern.
// ----------------------------------------------------------------------------
module fifo_distinct_recent_set_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frs_pkg::*;

    typedef struct packed {
        logic             kind;
        logic             inserted;
        logic             evicted;
        logic [ID_W-1:0]  evicted_id;
        logic [ID_W-1:0]  entry_value;
        logic             entry_valid;
        logic [CNT_W-1:0] count;
        logic             last;
    } rsp_t;

    typedef enum logic [0:0] {
        OP_ITEM      = 1'b0,
        OP_CAP_WRITE = 1'b1
    } plan_op_t;

    typedef struct {
        plan_op_t         op;
        logic             rq;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] cap;
        bit               typed;
        rsp_t             want;
    } plan_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;
    logic             req_valid;
    logic             req_ready;
    logic             req_type;
    logic [ID_W-1:0]  new_id;
    logic             rsp_valid;
    logic             rsp_ready;
    logic             kind;
    logic             inserted;
    logic             evicted;
    logic [ID_W-1:0]  evicted_id;
    logic [ID_W-1:0]  entry_value;
    logic             entry_valid;
    logic [CNT_W-1:0] count;
    logic             last;

    fifo_distinct_recent_set DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .new_id      (new_id),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .kind        (kind),
        .inserted    (inserted),
        .evicted     (evicted),
        .evicted_id  (evicted_id),
        .entry_value (entry_value),
        .entry_valid (entry_valid),
        .count       (count),
        .last        (last)
    );

    // Behavioral copy of the set
    logic [ID_W-1:0]  held_ids [DEPTH];
    logic [CNT_W-1:0] held_cnt;
    logic [CNT_W-1:0] cap_reg;

    rsp_t step_rsp [$];
    rsp_t pending_rsp [$];
    int   errors;
    int   burst_left;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1ms;
        $display("FAIL");
        $finish;
    end

    function automatic int eff_cap(logic [CNT_W-1:0] c);
        int v;
        v = c;
        if (v < 1) v = 1;
        if (v > DEPTH) v = DEPTH;
        return v;
    endfunction

    // Fills step_rsp with the items one request causes and updates the set.
    function automatic void predict_set_step(logic rq, logic [ID_W-1:0] id);
        bit   hit;
        rsp_t r;
        int   n;
        step_rsp.delete();
        r = '0;
        if (rq == REQ_OFFER)
        begin
            hit = 1'b0;
            for (int i = 0; i < held_cnt; i++)
                if (held_ids[i] == id) hit = 1'b1;
            if (!hit)
            begin
                if (held_cnt >= eff_cap(cap_reg))
                begin
                    r.evicted    = 1'b1;
                    r.evicted_id = held_ids[IDX_W'(held_cnt - CNT_W'(1))];
                    held_cnt     = held_cnt - CNT_W'(1);
                end
                for (int i = held_cnt; i > 0; i--)
                    held_ids[i] = held_ids[i-1];
                held_ids[0] = id;
                held_cnt    = held_cnt + CNT_W'(1);
            end
            r.kind     = KIND_OFFER;
            r.inserted = !hit;
            r.count    = held_cnt;
            r.last     = 1'b1;
            step_rsp   = {step_rsp, r};
        end
        else if (held_cnt == 0)
        begin
            r.kind   = KIND_ENTRY;
            r.last   = 1'b1;
            step_rsp = {step_rsp, r};
        end
        else
        begin
            n = (held_cnt > DEPTH) ? DEPTH : held_cnt;
            for (int i = 0; i < n; i++)
            begin
                r             = '0;
                r.kind        = KIND_ENTRY;
                r.entry_value = held_ids[i];
                r.entry_valid = 1'b1;
                r.count       = held_cnt;
                r.last        = (i == n - 1);
                step_rsp      = {step_rsp, r};
            end
        end
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= 50)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [ID_W-1:0] got, logic [ID_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Response monitor
    always @(posedge clk)
    begin
        rsp_t w;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                report_mismatch("item with nothing expected");
            end
            else
            begin
                w = pending_rsp.pop_front();
                check_field("kind", ID_W'(kind), ID_W'(w.kind));
                check_field("inserted", ID_W'(inserted), ID_W'(w.inserted));
                check_field("evicted", ID_W'(evicted), ID_W'(w.evicted));
                check_field("evicted_id", evicted_id, w.evicted_id);
                check_field("entry_value", entry_value, w.entry_value);
                check_field("entry_valid", ID_W'(entry_valid), ID_W'(w.entry_valid));
                check_field("count", ID_W'(count), ID_W'(w.count));
                check_field("last", ID_W'(last), ID_W'(w.last));
            end
        end
    end

    // Response-side stall pattern: picks a new random mode once the current one runs out
    initial
    begin
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (mode)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= ~rsp_ready;
                2: rsp_ready <= ($urandom_range(0, 3) != 0);
                default: rsp_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    task automatic send_item(logic rq, logic [ID_W-1:0] id, bit typed, rsp_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_type  <= rq;
        new_id    <= id;
        do @(posedge clk); while (!req_ready);
        burst_left--;
        predict_set_step(rq, id);
        if (typed)
            pending_rsp = {pending_rsp, want};
        else
            pending_rsp = {pending_rsp, step_rsp};
    endtask

    // Capacity writes only once the block has drained.
    task automatic write_capacity(logic [CNT_W-1:0] v);
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cap_reg  = v;
        held_cnt = '0;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        burst_left = 0;
    endtask

    function automatic rsp_t offer_rsp(logic ins, logic ev, logic [ID_W-1:0] ev_id,
                                       logic [CNT_W-1:0] cnt);
        rsp_t r;
        r            = '0;
        r.kind       = KIND_OFFER;
        r.inserted   = ins;
        r.evicted    = ev;
        r.evicted_id = ev_id;
        r.count      = cnt;
        r.last       = 1'b1;
        return r;
    endfunction

    function automatic rsp_t empty_read();
        rsp_t r;
        r      = '0;
        r.kind = KIND_ENTRY;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic plan_row_t row_item(logic rq, logic [ID_W-1:0] id);
        plan_row_t p;
        p.op    = OP_ITEM;
        p.rq    = rq;
        p.id    = id;
        p.cap   = '0;
        p.typed = 1'b0;
        p.want  = '0;
        return p;
    endfunction

    function automatic plan_row_t row_typed(logic rq, logic [ID_W-1:0] id, rsp_t want);
        plan_row_t p;
        p       = row_item(rq, id);
        p.typed = 1'b1;
        p.want  = want;
        return p;
    endfunction

    function automatic plan_row_t row_cap(logic [CNT_W-1:0] v);
        plan_row_t p;
        p     = row_item(REQ_OFFER, '0);
        p.op  = OP_CAP_WRITE;
        p.cap = v;
        return p;
    endfunction

    initial
    begin
        plan_row_t        plan [$];
        logic [CNT_W-1:0] phase_caps [10];
        logic [ID_W-1:0]  pool_base;
        logic [ID_W-1:0]  id;
        logic             rq;
        int               pool_size;
        int               pick;

        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        req_valid   = 1'b0;
        req_type    = REQ_OFFER;
        new_id      = '0;
        errors      = 0;
        burst_left  = 0;
        held_cnt    = '0;
        cap_reg     = CAP_RESET;
        foreach (held_ids[i]) held_ids[i] = '0;

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part
        plan = {plan, row_typed(REQ_READ, 32'h0, empty_read())};
        plan = {plan, row_typed(REQ_OFFER, 32'h0, offer_rsp(1'b1, 1'b0, '0, 5'd1))};
        plan = {plan, row_typed(REQ_OFFER, 32'hFFFF_FFFF,
                                offer_rsp(1'b1, 1'b0, '0, 5'd2))};
        plan = {plan, row_typed(REQ_OFFER, 32'h0, offer_rsp(1'b0, 1'b0, '0, 5'd2))};
        plan = {plan, row_item(REQ_READ, 32'hFFFF_FFFF)};
        // zero capacity behaves as one
        plan = {plan, row_cap(5'd0)};
        plan = {plan, row_typed(REQ_READ, 32'h0, empty_read())};
        plan = {plan, row_typed(REQ_OFFER, 32'h1234_5678,
                                offer_rsp(1'b1, 1'b0, '0, 5'd1))};
        plan = {plan, row_typed(REQ_OFFER, 32'h9ABC_DEF0,
                                offer_rsp(1'b1, 1'b1, 32'h1234_5678, 5'd1))};
        plan = {plan, row_typed(REQ_OFFER, 32'h9ABC_DEF0,
                                offer_rsp(1'b0, 1'b0, '0, 5'd1))};
        plan = {plan, row_item(REQ_READ, 32'h0)};
        plan = {plan, row_cap(5'd2)};
        plan = {plan, row_typed(REQ_OFFER, 32'h1, offer_rsp(1'b1, 1'b0, '0, 5'd1))};
        plan = {plan, row_typed(REQ_OFFER, 32'h2, offer_rsp(1'b1, 1'b0, '0, 5'd2))};
        plan = {plan, row_typed(REQ_OFFER, 32'h3, offer_rsp(1'b1, 1'b1, 32'h1, 5'd2))};
        // an evicted id comes back as new
        plan = {plan, row_typed(REQ_OFFER, 32'h1, offer_rsp(1'b1, 1'b1, 32'h2, 5'd2))};
        plan = {plan, row_item(REQ_READ, 32'h0)};
        // above DEPTH clamps to DEPTH
        plan = {plan, row_cap(5'd31)};
        plan = {plan, row_typed(REQ_READ, 32'hFFFF_FFFF, empty_read())};
        plan = {plan, row_typed(REQ_OFFER, 32'hAAAA_AAAA,
                                offer_rsp(1'b1, 1'b0, '0, 5'd1))};
        plan = {plan, row_typed(REQ_OFFER, 32'h5555_5555,
                                offer_rsp(1'b1, 1'b0, '0, 5'd2))};
        plan = {plan, row_item(REQ_READ, 32'h0)};

        foreach (plan[i])
        begin
            if (plan[i].op == OP_CAP_WRITE)
                write_capacity(plan[i].cap);
            else
                send_item(plan[i].rq, plan[i].id, plan[i].typed, plan[i].want);
        end

        // Random phases
        phase_caps = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd2, 5'd17, 5'd5, 5'd16, 5'd15, 5'd0};
        phase_caps[9] = CNT_W'($urandom_range(0, 31));
        foreach (phase_caps[p])
        begin
            write_capacity(phase_caps[p]);
            pool_base = $urandom;
            pool_size = eff_cap(phase_caps[p]) + $urandom_range(0, 6);
            for (int k = 0; k < 46; k++)
            begin
                pick = $urandom_range(0, 99);
                rq   = REQ_OFFER;
                if (pick < 12)
                begin
                    rq = REQ_READ;
                    id = $urandom;
                end
                else if (pick < 82)
                    id = pool_base + ID_W'($urandom_range(0, pool_size - 1));
                else if (pick < 94)
                    id = $urandom;
                else
                begin
                    case ($urandom_range(0, 3))
                        0: id = 32'h0;
                        1: id = 32'hFFFF_FFFF;
                        2: id = 32'h8000_0000;
                        default: id = 32'h1;
                    endcase
                end
                send_item(rq, id, 1'b0, '0);
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
